### rtl/nhtm_pkg.sv
`default_nettype none
package nhtm_pkg;

   localparam int NODES_DEFAULT = 64;
   localparam int MAX_REPORTS   = 64;

   localparam int NODE_W  = 6;
   localparam int TIME_W  = 32;
   localparam int SIZE_W  = 9;
   localparam int COUNT_W = 7;
   localparam int KIND_W  = 2;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_NETWORK_SIZE      = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_MEDIUM_SIZE_FROM  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_LARGE_SIZE_FROM   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_SMALL_TIMEOUT_US  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_MEDIUM_TIMEOUT_US = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_LARGE_TIMEOUT_US  = 3'd5;

   localparam logic [SIZE_W-1:0] NETWORK_SIZE_RESET      = 9'd1;
   localparam logic [SIZE_W-1:0] MEDIUM_SIZE_FROM_RESET  = 9'd50;
   localparam logic [SIZE_W-1:0] LARGE_SIZE_FROM_RESET   = 9'd150;
   localparam logic [TIME_W-1:0] SMALL_TIMEOUT_US_RESET  = 32'd950000;
   localparam logic [TIME_W-1:0] MEDIUM_TIMEOUT_US_RESET = 32'd1250000;
   localparam logic [TIME_W-1:0] LARGE_TIMEOUT_US_RESET  = 32'd1750000;

   localparam logic MODE_HEARTBEAT = 1'b0;
   localparam logic MODE_CHECK     = 1'b1;

   localparam logic [KIND_W-1:0] KIND_HEARTBEAT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DOWN      = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NONE      = 2'd2;

   typedef struct packed {
      logic              mode;
      logic [NODE_W-1:0] node;
      logic [TIME_W-1:0] now_us;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [NODE_W-1:0]  node_id;
      logic               newly_up;
      logic [COUNT_W-1:0] down_count;
      logic               last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic heartbeat;
      logic check_load;
      logic scan_read;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic addr_last;
   } status_type;

endpackage
`default_nettype wire

### rtl/nhtm_csr.sv
`default_nettype none
module nhtm_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [nhtm_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [nhtm_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [nhtm_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                  pready,
   output logic      [nhtm_pkg::TIME_W-1:0]      limit
);
   import nhtm_pkg::*;

   logic [SIZE_W-1:0]    network_size_ff,  network_size_in;
   logic [SIZE_W-1:0]    medium_from_ff,   medium_from_in;
   logic [SIZE_W-1:0]    large_from_ff,    large_from_in;
   logic [TIME_W-1:0]    small_to_ff,      small_to_in;
   logic [TIME_W-1:0]    medium_to_ff,     medium_to_in;
   logic [TIME_W-1:0]    large_to_ff,      large_to_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_en;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;

   always_comb begin
      network_size_in = network_size_ff;
      medium_from_in  = medium_from_ff;
      large_from_in   = large_from_ff;
      small_to_in     = small_to_ff;
      medium_to_in    = medium_to_ff;
      large_to_in     = large_to_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_NETWORK_SIZE:      network_size_in = pwdata[SIZE_W-1:0];
            REG_MEDIUM_SIZE_FROM:  medium_from_in  = pwdata[SIZE_W-1:0];
            REG_LARGE_SIZE_FROM:   large_from_in   = pwdata[SIZE_W-1:0];
            REG_SMALL_TIMEOUT_US:  small_to_in     = pwdata[TIME_W-1:0];
            REG_MEDIUM_TIMEOUT_US: medium_to_in    = pwdata[TIME_W-1:0];
            REG_LARGE_TIMEOUT_US:  large_to_in     = pwdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         network_size_ff <= NETWORK_SIZE_RESET;
         medium_from_ff  <= MEDIUM_SIZE_FROM_RESET;
         large_from_ff   <= LARGE_SIZE_FROM_RESET;
         small_to_ff     <= SMALL_TIMEOUT_US_RESET;
         medium_to_ff    <= MEDIUM_TIMEOUT_US_RESET;
         large_to_ff     <= LARGE_TIMEOUT_US_RESET;
      end else begin
         network_size_ff <= network_size_in;
         medium_from_ff  <= medium_from_in;
         large_from_ff   <= large_from_in;
         small_to_ff     <= small_to_in;
         medium_to_ff    <= medium_to_in;
         large_to_ff     <= large_to_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_NETWORK_SIZE:      prdata = CSR_DATA_W'(network_size_ff);
         REG_MEDIUM_SIZE_FROM:  prdata = CSR_DATA_W'(medium_from_ff);
         REG_LARGE_SIZE_FROM:   prdata = CSR_DATA_W'(large_from_ff);
         REG_SMALL_TIMEOUT_US:  prdata = CSR_DATA_W'(small_to_ff);
         REG_MEDIUM_TIMEOUT_US: prdata = CSR_DATA_W'(medium_to_ff);
         REG_LARGE_TIMEOUT_US:  prdata = CSR_DATA_W'(large_to_ff);
         default:               prdata = '0;
      endcase
   end

   // large tier wins when thresholds cross
   always_comb begin
      priority if (network_size_ff >= large_from_ff) begin
         limit = large_to_ff;
      end else if (network_size_ff >= medium_from_ff) begin
         limit = medium_to_ff;
      end else begin
         limit = small_to_ff;
      end
   end

endmodule
`default_nettype wire

### rtl/nhtm_ctrl.sv
`default_nettype none
module nhtm_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic                   mode,
   input  wire nhtm_pkg::status_type   status,
   output nhtm_pkg::cmd_type           cmd,
   output logic                        busy
);
   import nhtm_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               if (mode == MODE_CHECK) begin
                  cmd.check_load = 1'b1;
                  state_in       = ST_SCAN;
               end else begin
                  cmd.heartbeat = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_read = 1'b1;
            if (status.addr_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

### rtl/nhtm_datapath.sv
`default_nettype none
module nhtm_datapath #(
   parameter int NODES = nhtm_pkg::NODES_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire nhtm_pkg::cmd_type     cmd,
   output nhtm_pkg::status_type       status,
   input  wire nhtm_pkg::req_type     req_data,
   input  wire logic [nhtm_pkg::TIME_W-1:0] limit,
   output logic                       rsp_strobe,
   output nhtm_pkg::rsp_type          rsp_data
);
   import nhtm_pkg::*;

   localparam int IW = $clog2(NODES);
   localparam int EW = IW + NODE_W;

   logic [TIME_W-1:0]  last_heard_mem [NODES];

   logic [NODES-1:0]   up_ff, up_in;
   logic [IW-1:0]      addr_ff, addr_in;
   logic [IW-1:0]      rd_idx_ff;
   logic [TIME_W-1:0]  rd_data_ff;
   logic               cmp_valid_ff;
   logic [TIME_W-1:0]  now_ff;
   logic [TIME_W-1:0]  limit_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [IW-1:0]      pend_idx_ff, pend_idx_in;
   logic [COUNT_W-1:0] pend_count_ff, pend_count_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_ff, rsp_in;

   logic [EW-1:0]      node_ext;
   logic [EW-1:0]      pend_ext;
   logic [IW-1:0]      node_idx;
   logic               in_range;
   logic [TIME_W-1:0]  elapsed;
   logic               hit;

   assign node_ext = EW'(req_data.node);
   assign pend_ext = EW'(pend_idx_ff);
   assign node_idx = node_ext[IW-1:0];
   assign in_range = node_ext < EW'(NODES);
   assign elapsed  = now_ff - rd_data_ff;
   assign hit      = cmp_valid_ff && up_ff[rd_idx_ff] && (elapsed >= limit_ff)
                     && (count_ff < COUNT_W'(MAX_REPORTS));

   assign status.addr_last = (addr_ff == IW'(NODES - 1));

   always_ff @(posedge clock) begin
      if (cmd.heartbeat && in_range) begin
         last_heard_mem[node_idx] <= req_data.now_us;
      end
      if (cmd.scan_read) begin
         rd_data_ff <= last_heard_mem[addr_ff];
      end
   end

   always_comb begin
      up_in         = up_ff;
      addr_in       = addr_ff;
      count_in      = count_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      pend_count_in = pend_count_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;

      if (cmd.heartbeat) begin
         if (in_range) begin
            up_in[node_idx] = 1'b1;
         end
         rsp_strobe_in     = 1'b1;
         rsp_in.kind       = KIND_HEARTBEAT;
         rsp_in.node_id    = req_data.node;
         rsp_in.newly_up   = in_range && !up_ff[node_idx];
         rsp_in.down_count = '0;
         rsp_in.last       = 1'b1;
      end

      if (cmd.check_load) begin
         addr_in       = '0;
         count_in      = '0;
         pend_valid_in = 1'b0;
      end

      if (cmd.scan_read) begin
         addr_in = addr_ff + IW'(1);
      end

      // a down beat goes out once the next one is found, so the last flag is known
      if (hit) begin
         up_in[rd_idx_ff] = 1'b0;
         count_in         = count_ff + COUNT_W'(1);
         pend_valid_in    = 1'b1;
         pend_idx_in      = rd_idx_ff;
         pend_count_in    = count_ff + COUNT_W'(1);
         if (pend_valid_ff) begin
            rsp_strobe_in     = 1'b1;
            rsp_in.kind       = KIND_DOWN;
            rsp_in.node_id    = pend_ext[NODE_W-1:0];
            rsp_in.newly_up   = 1'b0;
            rsp_in.down_count = pend_count_ff;
            rsp_in.last       = 1'b0;
         end
      end

      if (cmd.finish) begin
         rsp_strobe_in   = 1'b1;
         rsp_in.newly_up = 1'b0;
         rsp_in.last     = 1'b1;
         if (pend_valid_ff) begin
            rsp_in.kind       = KIND_DOWN;
            rsp_in.node_id    = pend_ext[NODE_W-1:0];
            rsp_in.down_count = pend_count_ff;
         end else begin
            rsp_in.kind       = KIND_NONE;
            rsp_in.node_id    = '0;
            rsp_in.down_count = '0;
         end
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff         <= '0;
         addr_ff       <= '0;
         count_ff      <= '0;
         cmp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         up_ff         <= up_in;
         addr_ff       <= addr_in;
         count_ff      <= count_in;
         cmp_valid_ff  <= cmd.scan_read;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= addr_ff;
      pend_idx_ff   <= pend_idx_in;
      pend_count_ff <= pend_count_in;
      rsp_ff        <= rsp_in;
      if (cmd.check_load) begin
         now_ff   <= req_data.now_us;
         limit_ff <= limit;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
`default_nettype wire

### rtl/neighbor_heartbeat_timeout_monitor_top.sv
// Heartbeat: taken while idle, reply comes out the cycle after; a new item may follow at once.
// Check: scans one node a cycle through the last-heard memory's single read port;
//   a down beat is held until the next one is found or the check finishes, the final beat comes
//   out in the same cycle that busy drops; busy through the scan, drain and finish states.
// Results appear for one cycle on rsp_strobe; the receiver cannot stall.
// Synchronous reset: every node down, registers at their defaults, no clearing pass.
`default_nettype none
module neighbor_heartbeat_timeout_monitor_top #(
   parameter int NODES = nhtm_pkg::NODES_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire nhtm_pkg::req_type                req_data,
   output logic                                  rsp_strobe,
   output nhtm_pkg::rsp_type                     rsp_data,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [nhtm_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [nhtm_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [nhtm_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                  pready
);
   import nhtm_pkg::*;

   cmd_type           cmd;
   status_type        status;
   logic [TIME_W-1:0] limit;

   nhtm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .limit   (limit)
   );

   nhtm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .mode   (req_data.mode),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   nhtm_datapath #(
      .NODES (NODES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_data   (req_data),
      .limit      (limit),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire
